### design/array_list_insert_remove_core_macros.svh
// assertion macros for the array list core
// depends on a clock named clk and a reset named rst in the using module
`ifndef ARRAY_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define ARRAY_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ALI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("array list core check failed");

// next-cycle implication, checked outside reset
`define ALI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("array list core check failed");

`endif

### design/alist_pkg.sv
// shared types and constants for the array list core
// no dependencies
package alist_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = 7;
  localparam int DW    = 32;
  localparam int CMPW  = ((CW > PW) ? CW : PW) + 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_TAKE_RD,
    S_TAKE_WR,
    S_DN_RD,
    S_DN_WR,
    S_FINISH,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_UP,
    RD_POS,
    RD_DN
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_VAL,
    WR_DN
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    check;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    take;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic insert;
    logic tail;
    logic at_pos;
    logic dn_last;
  } stat_t;

endpackage

### design/alist_ctrl.sv
// sequencer for the array list core: handshakes and shift steps
// depends on alist_pkg
module alist_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  alist_pkg::stat_t     stat,
  output alist_pkg::cmd_t      cmd
);
  import alist_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.err) begin
          state_next = S_FINISH;
        end else if (stat.insert) begin
          state_next = stat.tail ? S_PUT : S_UP_RD;
        end else begin
          state_next = S_TAKE_RD;
        end
      end
      S_UP_RD:   state_next = S_UP_WR;
      S_UP_WR:   state_next = stat.at_pos ? S_PUT : S_UP_RD;
      S_PUT:     state_next = S_FINISH;
      S_TAKE_RD: state_next = S_TAKE_WR;
      S_TAKE_WR: state_next = stat.tail ? S_FINISH : S_DN_RD;
      S_DN_RD:   state_next = S_DN_WR;
      S_DN_WR:   state_next = stat.dn_last ? S_FINISH : S_DN_RD;
      S_FINISH:  state_next = S_OUT;
      S_OUT:     if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.rd     = RD_NONE;
    cmd.wr     = WR_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK:   cmd.check = 1'b1;
      S_UP_RD:   cmd.rd = RD_UP;
      S_UP_WR:   cmd.wr = WR_UP;
      S_PUT:     cmd.wr = WR_VAL;
      S_TAKE_RD: cmd.rd = RD_POS;
      S_TAKE_WR: cmd.take = 1'b1;
      S_DN_RD:   cmd.rd = RD_DN;
      S_DN_WR:   cmd.wr = WR_DN;
      S_FINISH:  cmd.finish = 1'b1;
      S_OUT:     out_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/alist_dp.sv
// datapath of the array list core: entry memory, count, walk index, result
// depends on alist_pkg
module alist_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  alist_pkg::cmd_t               cmd,
  output alist_pkg::stat_t              stat,
  input  logic                          kind,
  input  logic [alist_pkg::PW-1:0]      position,
  input  logic [alist_pkg::DW-1:0]      value,
  output logic [alist_pkg::DW-1:0]      removed_value,
  output logic [1:0]                    status,
  output logic [alist_pkg::PW-1:0]      count
);
  import alist_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata;

  logic          op_remove;
  logic [PW-1:0] op_pos;
  logic [DW-1:0] op_val;
  logic [CW-1:0] entry_count;
  logic [AW-1:0] idx;
  status_t       status_q;
  status_t       status_calc;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] idx_x;
  logic [AW-1:0]   pos_a;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic [DW-1:0]   wdata;

  assign pos_x = CMPW'(op_pos);
  assign cnt_x = CMPW'(entry_count);
  assign idx_x = CMPW'(idx);
  assign pos_a = pos_x[AW-1:0];

  // error checks, full or empty take priority over range
  always_comb begin
    status_calc = ST_OK;
    if (!op_remove) begin
      if (entry_count == CW'(DEPTH)) begin
        status_calc = ST_FULL;
      end else if (pos_x > cnt_x) begin
        status_calc = ST_RANGE;
      end
    end else begin
      if (entry_count == '0) begin
        status_calc = ST_EMPTY;
      end else if (pos_x >= cnt_x) begin
        status_calc = ST_RANGE;
      end
    end
  end

  always_comb begin
    stat.err     = (status_calc != ST_OK);
    stat.insert  = !op_remove;
    stat.tail    = op_remove ? (pos_x + CMPW'(1) == cnt_x) : (pos_x == cnt_x);
    stat.at_pos  = (idx_x == pos_x + CMPW'(1));
    stat.dn_last = (idx_x + CMPW'(2) == cnt_x);
  end

  always_comb begin
    case (cmd.rd)
      RD_UP:   raddr = idx - AW'(1);
      RD_POS:  raddr = pos_a;
      RD_DN:   raddr = idx + AW'(1);
      default: raddr = idx;
    endcase
    case (cmd.wr)
      WR_VAL:  waddr = pos_a;
      default: waddr = idx;
    endcase
    wdata = (cmd.wr == WR_VAL) ? op_val : rdata;
  end

  // entry memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd != RD_NONE) begin
      rdata <= mem[raddr];
    end
    if (cmd.wr != WR_NONE) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_remove     <= kind;
      op_pos        <= position;
      op_val        <= value;
      removed_value <= '0;
    end
    if (cmd.check) begin
      status_q <= status_calc;
      idx      <= op_remove ? pos_a : entry_count[AW-1:0];
    end else begin
      case (cmd.wr)
        WR_UP:   idx <= idx - AW'(1);
        WR_DN:   idx <= idx + AW'(1);
        default: idx <= idx;
      endcase
    end
    if (cmd.take) begin
      removed_value <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.finish && status_q == ST_OK) begin
      entry_count <= op_remove ? entry_count - CW'(1) : entry_count + CW'(1);
    end
  end

  assign status = status_q;
  assign count  = entry_count[PW-1:0];

endmodule

### design/array_list_insert_remove_core.sv
// top level of the array list core: sequencer plus datapath
// depends on alist_pkg, alist_ctrl, alist_dp and the assertion macro header
`include "array_list_insert_remove_core_macros.svh"

// ordered list of up to DEPTH 32-bit entry words held in a single-port-write,
// registered-read memory with an entry count. each input item inserts value
// at position (kind 0) or removes the entry at position (kind 1); position 0
// is the head, count is the tail for insert and count-1 for remove. every item
// gives exactly one result: the removed word (zero for inserts and errors), a
// status (ok, full, empty, position out of range; full and empty are checked
// first) and the count after the item. on an error the list is unchanged.
// items are handled one at a time. the shift walks the memory one entry at
// a time, a read step then a write step per entry; the block is ready again
// the cycle after its result is taken. there is no clearing pass after
// reset: only entries below the count are ever read.
module array_list_insert_remove_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [alist_pkg::PW-1:0]   position,
  input  logic [alist_pkg::DW-1:0]   value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [alist_pkg::DW-1:0]   removed_value,
  output logic [1:0]                 status,
  output logic [alist_pkg::PW-1:0]   count
);
  import alist_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: handshakes and the shift walk
  alist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memory, count and result registers
  alist_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .position      (position),
    .value         (value),
    .removed_value (removed_value),
    .status        (status),
    .count         (count)
  );

  // one item in flight: never taking input while a result is shown
  `ALI_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  // an accepted item is checked before any result shows
  `ALI_ASSERT_NEXT(a_accept_no_result, in_valid && in_ready, !out_valid)
  // once a result is taken the block is ready again
  `ALI_ASSERT_NEXT(a_ready_after_out, out_valid && out_ready, in_ready)
  // failed items never carry a removed word
  `ALI_ASSERT_IMP(a_err_zero, out_valid && (status != ST_OK), removed_value == '0)

endmodule
